@@ rtl/sfp_pkg.sv @@
// sfp_pkg: shared types and constants for the SysEx frame parser.
// No dependencies; imported by the interfaces and all rtl modules.
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CAP_W       = 13;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;

   // hard limit on raw bytes per message, wide enough for its full range
   localparam logic [16:0] MAX_RAW = 17'd4096;

   localparam logic [CAP_W-1:0] CAP_RESET  = 13'd4096;
   localparam logic [2:0]       GROUP_HIGH = 3'd0;
   localparam logic [2:0]       GROUP_FIRST = 3'd1;
   localparam logic [2:0]       GROUP_LAST = 3'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAKER,
      CSR_FAMILY,
      CSR_APP,
      CSR_VERSION,
      CSR_DUMP,
      CSR_CAPACITY
   } csr_idx_type;

   typedef enum logic [3:0] {
      POS_MAKER,
      POS_FAMILY,
      POS_APP,
      POS_VERSION,
      POS_COMMAND,
      POS_SEQ_LO,
      POS_SEQ_HI,
      POS_TOT_LO,
      POS_TOT_HI,
      POS_DUMP,
      POS_PASS
   } pos_type;

   typedef enum logic [2:0] {
      STS_OK,
      STS_SHORT,
      STS_ID,
      STS_VERSION,
      STS_MALFORMED,
      STS_OVERFLOW
   } sts_type;

   typedef struct packed {
      logic [BYTE_W-1:0] maker_id;
      logic [BYTE_W-1:0] family_code;
      logic [BYTE_W-1:0] app_code;
      logic [BYTE_W-1:0] protocol_version;
      logic [BYTE_W-1:0] dump_command;
      logic [CAP_W-1:0]  raw_capacity;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
      sts_type           status;
      logic [BYTE_W-1:0] command;
      logic [WORD_W-1:0] sequence_res;
      logic [WORD_W-1:0] total;
      logic [CAP_W-1:0]  raw_length;
      logic              end_flag;
   } rsp_type;

   // up to two results per input beat: data first, then status
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

@@ rtl/sfp_if.sv @@
// sfp_req_if / sfp_rsp_if: valid/ready channels of the SysEx frame parser.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

interface sfp_req_if;
   import sfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfp_rsp_if;
   import sfp_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] data_byte;
   logic [2:0]        status;
   logic [BYTE_W-1:0] command;
   logic [WORD_W-1:0] sequence_res;
   logic [WORD_W-1:0] total;
   logic [CAP_W-1:0]  raw_length;
   logic              end_flag;

   modport source (output valid, output kind, output data_byte, output status,
                   output command, output sequence_res, output total,
                   output raw_length, output end_flag, input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input command, input sequence_res, input total,
                   input raw_length, input end_flag, output ready);
endinterface

@@ rtl/sfp_csr.sv @@
// sfp_csr: configuration registers of the SysEx frame parser.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sfp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output sfp_pkg::cfg_type                 cfg
);
   import sfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_MAKER:    cfg_in.maker_id         = csr_wr_data[BYTE_W-1:0];
            CSR_FAMILY:   cfg_in.family_code      = csr_wr_data[BYTE_W-1:0];
            CSR_APP:      cfg_in.app_code         = csr_wr_data[BYTE_W-1:0];
            CSR_VERSION:  cfg_in.protocol_version = csr_wr_data[BYTE_W-1:0];
            CSR_DUMP:     cfg_in.dump_command     = csr_wr_data[BYTE_W-1:0];
            CSR_CAPACITY: cfg_in.raw_capacity     = csr_wr_data[CAP_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{maker_id: '0, family_code: '0, app_code: '0,
                     protocol_version: '0, dump_command: '0,
                     raw_capacity: CAP_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/sfp_decode.sv @@
// sfp_decode: per-beat header check, dump header capture and 7-bit unpack.
// Holds the message state; emits up to two results per beat. Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [sfp_pkg::BYTE_W-1:0]   in_byte,
   input  logic                         in_last,
   input  sfp_pkg::cfg_type             cfg,
   output sfp_pkg::push_type            push
);
   import sfp_pkg::*;

   pos_type           pos_ff, pos_in;
   logic              id_bad_ff, id_bad_in;
   logic              ver_bad_ff, ver_bad_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic [WORD_W-1:0] tot_ff, tot_in;
   logic [BYTE_W-1:0] hbits_ff, hbits_in;
   logic [2:0]        grp_ff, grp_in;
   logic [CAP_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;

   logic              have_raw;
   logic [BYTE_W-1:0] raw;
   logic [2:0]        bit_sel;
   logic              room;
   logic              gated;
   logic              emit;
   sts_type           sts;
   rsp_type           data_rsp;
   rsp_type           sts_rsp;

   assign room = ({4'd0, cnt_ff} < {4'd0, cfg.raw_capacity}) && ({4'd0, cnt_ff} < MAX_RAW);

   // next state
   always_comb begin
      pos_in     = pos_ff;
      id_bad_in  = id_bad_ff;
      ver_bad_in = ver_bad_ff;
      cmd_in     = cmd_ff;
      seq_in     = seq_ff;
      tot_in     = tot_ff;
      hbits_in   = hbits_ff;
      grp_in     = grp_ff;
      have_raw   = 1'b0;
      raw        = in_byte;
      bit_sel    = grp_ff - 3'd1;
      case (pos_ff)
         POS_MAKER: begin
            if (in_byte != cfg.maker_id) id_bad_in = 1'b1;
            pos_in = POS_FAMILY;
         end
         POS_FAMILY: begin
            if (in_byte != cfg.family_code) id_bad_in = 1'b1;
            pos_in = POS_APP;
         end
         POS_APP: begin
            if (in_byte != cfg.app_code) id_bad_in = 1'b1;
            pos_in = POS_VERSION;
         end
         POS_VERSION: begin
            if (in_byte != cfg.protocol_version) ver_bad_in = 1'b1;
            pos_in = POS_COMMAND;
         end
         POS_COMMAND: begin
            cmd_in = in_byte;
            pos_in = (in_byte == cfg.dump_command) ? POS_SEQ_LO : POS_PASS;
         end
         POS_SEQ_LO: begin
            seq_in = {8'd0, in_byte};
            pos_in = POS_SEQ_HI;
         end
         POS_SEQ_HI: begin
            seq_in = seq_ff + {1'b0, in_byte, 7'd0};
            pos_in = POS_TOT_LO;
         end
         POS_TOT_LO: begin
            tot_in = {8'd0, in_byte};
            pos_in = POS_TOT_HI;
         end
         POS_TOT_HI: begin
            tot_in = tot_ff + {1'b0, in_byte, 7'd0};
            pos_in = POS_DUMP;
         end
         POS_DUMP: begin
            if (grp_ff == GROUP_HIGH) begin
               hbits_in = in_byte;
               grp_in   = GROUP_FIRST;
            end else begin
               raw      = {hbits_ff[bit_sel], in_byte[6:0]};
               have_raw = 1'b1;
               grp_in   = (grp_ff == GROUP_LAST) ? GROUP_HIGH : grp_ff + 3'd1;
            end
         end
         default: begin
            pos_in   = POS_PASS;
            have_raw = 1'b1;
         end
      endcase

      gated  = have_raw && !id_bad_in && !ver_bad_in;
      emit   = gated && room;
      ovf_in = ovf_ff || (gated && !room);
      cnt_in = cnt_ff + CAP_W'(emit);
   end

   // results
   always_comb begin
      if (pos_in < POS_SEQ_LO)                           sts = STS_SHORT;
      else if (id_bad_in)                                sts = STS_ID;
      else if (ver_bad_in)                               sts = STS_VERSION;
      else if (pos_in < POS_DUMP)                        sts = STS_SHORT;
      else if (pos_in == POS_DUMP && grp_in == GROUP_FIRST) sts = STS_MALFORMED;
      else if (ovf_in)                                   sts = STS_OVERFLOW;
      else                                               sts = STS_OK;

      data_rsp           = '0;
      data_rsp.data_byte = raw;
      data_rsp.status    = STS_OK;

      sts_rsp              = '0;
      sts_rsp.kind         = 1'b1;
      sts_rsp.status       = sts;
      sts_rsp.command      = cmd_in;
      sts_rsp.sequence_res = seq_in;
      sts_rsp.total        = tot_in;
      sts_rsp.raw_length   = cnt_in;
      sts_rsp.end_flag     = 1'b1;

      push.count  = fire ? (2'(emit) + 2'(in_last)) : 2'd0;
      push.first  = emit ? data_rsp : sts_rsp;
      push.second = sts_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && in_last)) begin
         pos_ff     <= POS_MAKER;
         id_bad_ff  <= 1'b0;
         ver_bad_ff <= 1'b0;
         cmd_ff     <= '0;
         seq_ff     <= '0;
         tot_ff     <= '0;
         hbits_ff   <= '0;
         grp_ff     <= GROUP_HIGH;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else if (fire) begin
         pos_ff     <= pos_in;
         id_bad_ff  <= id_bad_in;
         ver_bad_ff <= ver_bad_in;
         cmd_ff     <= cmd_in;
         seq_ff     <= seq_in;
         tot_ff     <= tot_in;
         hbits_ff   <= hbits_in;
         grp_ff     <= grp_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

@@ rtl/sfp_rsp_fifo.sv @@
// sfp_rsp_fifo: result queue taking up to two beats per cycle, one out while out_ready is high.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_rsp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  sfp_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output sfp_pkg::rsp_type    out_data
);
   import sfp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   rsp_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;

   assign wr_next   = wrap_inc(wr_ptr_ff);
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];
   assign room      = (cnt_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      case (push.count)
         2'd0:    wr_ptr_in = wr_ptr_ff;
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = wrap_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/sysex_frame_parser.sv @@
// sysex_frame_parser: SysEx header check and 7-bit group unpacking, top level.
// Depends on sfp_pkg, sfp_if, sfp_csr, sfp_decode, sfp_rsp_fifo.
//
//   channel   dir   beat
//   req_bus   in    in_byte, in_last
//   rsp_bus   out   kind, data_byte, status, command, sequence_res, total,
//                   raw_length, end_flag
//   csr_*     in    wr_en, index, wr_data (write only)
//
// One message byte is decoded per cycle, while the queue has room, straight into the result queue.
// A byte makes zero, one or two results; a final byte that also emits data
// makes two, so the output side sets the rate at that point.
// req ready drops when fewer than two queue slots are free.
// Synchronous reset clears message state and queue, and resets the registers (raw capacity to 4096); no clear pass.
`timescale 1ns / 1ps

module sysex_frame_parser #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   sfp_req_if.sink                         req_bus,
   sfp_rsp_if.source                       rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [sfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sfp_pkg::*;

   cfg_type  cfg;
   push_type push;
   rsp_type  rsp_data;
   logic     room;
   logic     req_fire;

   assign req_bus.ready = room;
   assign req_fire      = req_bus.valid && room;

   sfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   sfp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (req_fire),
      .in_byte (req_bus.in_byte),
      .in_last (req_bus.in_last),
      .cfg     (cfg),
      .push    (push)
   );

   sfp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.kind         = rsp_data.kind;
   assign rsp_bus.data_byte    = rsp_data.data_byte;
   assign rsp_bus.status       = rsp_data.status;
   assign rsp_bus.command      = rsp_data.command;
   assign rsp_bus.sequence_res = rsp_data.sequence_res;
   assign rsp_bus.total        = rsp_data.total;
   assign rsp_bus.raw_length   = rsp_data.raw_length;
   assign rsp_bus.end_flag     = rsp_data.end_flag;

   a_last_gives_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.in_last |=> rsp_bus.valid)
      else $error("final byte left no result queued");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.kind |-> rsp_bus.end_flag && rsp_bus.data_byte == 8'd0)
      else $error("status beat malformed");

   a_data_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.kind |->
         !rsp_bus.end_flag && rsp_bus.status == STS_OK && rsp_bus.raw_length == 13'd0)
      else $error("data beat carries status fields");

endmodule
